FILE: hdl/fovr_pkg.sv
// shared constants and types for the field-oriented vector rotator
`timescale 1ns / 1ps

package fovr_pkg;

    typedef logic [31:0] turn_t;

    localparam int CORDIC_STEPS = 30;
    localparam int TURN_BITS    = 32;
    localparam int PRE_SHIFT    = 14;
    localparam int ROUND_SHIFT  = 16;
    localparam int ROUND_HALF   = 32768;

    // cordic gain 0.6072529 in q30
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

    // quarter turn in 2^32 per turn
    localparam logic signed [TURN_BITS-1:0] QUARTER_TURN = 32'sh4000_0000;

    // arctangent of 2^-i in 2^32 per turn
    localparam turn_t ATAN_TURN32 [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

endpackage

FILE: hdl/fovr_cordic_step.sv
// one cordic rotation step with fixed shift and arctangent constant
`timescale 1ns / 1ps

module fovr_cordic_step #(
    parameter int XW   = 34,
    parameter int STEP = 0
) (
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic signed [31:0]   z_in,
    output logic signed [XW-1:0] x_out,
    output logic signed [XW-1:0] y_out,
    output logic signed [31:0]   z_out
);
    import fovr_pkg::*;

    localparam logic signed [31:0] ATAN_STEP = $signed(ATAN_TURN32[STEP]);

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    assign dx = y_in >>> STEP;
    assign dy = x_in >>> STEP;

    always_comb
    begin
        if (!z_in[31])
        begin
            x_out = x_in - dx;
            y_out = y_in + dy;
            z_out = z_in - ATAN_STEP;
        end
        else
        begin
            x_out = x_in + dx;
            y_out = y_in - dy;
            z_out = z_in + ATAN_STEP;
        end
    end

endmodule

FILE: hdl/field_oriented_vector_rotate_core.sv
// top level: pipelined cordic rotation of the drive vector by minus the heading
// 33 register stages: input reg, gain multiply, 30 cordic steps, round and saturate;
// the input reg loads on accept. throughput: one word per cycle while out_ready is high;
// each stage holds only while all later stages are full
// reset: valid bits of every stage clear, payload registers are not reset
`timescale 1ns / 1ps

module field_oriented_vector_rotate_core #(
    parameter int DATA_WIDTH  = 16,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] cmd_x,
    input  logic signed [DATA_WIDTH-1:0] cmd_y,
    input  logic signed [DATA_WIDTH-1:0] cmd_rot,
    input  logic [ANGLE_WIDTH-1:0]       heading,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] out_x,
    output logic signed [DATA_WIDTH-1:0] out_y,
    output logic signed [DATA_WIDTH-1:0] out_rot
);
    import fovr_pkg::*;

    localparam int XW    = DATA_WIDTH + 18;
    localparam int PW    = DATA_WIDTH + 32;
    localparam int RW    = XW - ROUND_SHIFT;
    localparam int LAST  = CORDIC_STEPS + 2;
    localparam int NST   = CORDIC_STEPS + 3;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [NST-1:0] adv;

    logic signed [DATA_WIDTH-1:0]  rot_reg [NST];

    logic signed [DATA_WIDTH-1:0]  x0_reg;
    logic signed [DATA_WIDTH-1:0]  y0_reg;
    logic [ANGLE_WIDTH-1:0]        h0_reg;

    logic signed [PW-1:0]          px;
    logic signed [PW-1:0]          py;
    logic [TURN_BITS-1:0]          h_turn;
    logic signed [TURN_BITS-1:0]   z_raw;
    logic                          far;
    logic signed [XW-1:0]          x1_next;
    logic signed [XW-1:0]          y1_next;
    logic signed [TURN_BITS-1:0]   z1_next;

    logic signed [XW-1:0]          x1_reg;
    logic signed [XW-1:0]          y1_reg;
    logic signed [TURN_BITS-1:0]   z1_reg;
    logic                          flip1_reg;

    logic signed [XW-1:0]          x_neg;
    logic signed [XW-1:0]          y_neg;

    logic signed [XW-1:0]          xs_reg  [CORDIC_STEPS];
    logic signed [XW-1:0]          ys_reg  [CORDIC_STEPS];
    logic signed [TURN_BITS-1:0]   zs_reg  [CORDIC_STEPS];
    logic signed [XW-1:0]          xs_next [CORDIC_STEPS];
    logic signed [XW-1:0]          ys_next [CORDIC_STEPS];
    logic signed [TURN_BITS-1:0]   zs_next [CORDIC_STEPS];

    logic signed [DATA_WIDTH-1:0]  out_x_reg;
    logic signed [DATA_WIDTH-1:0]  out_y_reg;
    logic signed [DATA_WIDTH-1:0]  out_x_next;
    logic signed [DATA_WIDTH-1:0]  out_y_next;

    function automatic logic signed [DATA_WIDTH-1:0] round_sat(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] sum;
        logic signed [RW-1:0] r;
        logic                 fits;
        sum  = v + XW'(ROUND_HALF);
        r    = sum[XW-1:ROUND_SHIFT];
        fits = (&r[RW-1:DATA_WIDTH-1]) || !(|r[RW-1:DATA_WIDTH-1]);
        if (fits)
        begin
            round_sat = r[DATA_WIDTH-1:0];
        end
        else
        begin
            round_sat = {r[RW-1], {(DATA_WIDTH-1){~r[RW-1]}}};
        end
    endfunction

    // per-stage handshake: a stage moves when it is empty or the next one moves
    always_comb
    begin
        adv[LAST] = !valid_reg[LAST] || out_ready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < NST; k++)
        begin
            if (!adv[k])
            begin
                valid_next[k] = valid_reg[k];
            end
            else if (k == 0)
            begin
                valid_next[k] = in_valid;
            end
            else
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[LAST];

    // rotation command shift line
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            rot_reg[0] <= cmd_rot;
        end
        for (int k = 1; k < NST; k++)
        begin
            if (adv[k])
            begin
                rot_reg[k] <= rot_reg[k-1];
            end
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            x0_reg <= cmd_x;
            y0_reg <= cmd_y;
            h0_reg <= heading;
        end
    end

    // gain prescale and phase fold into plus or minus a quarter turn
    assign px      = x0_reg * GAIN_Q30;
    assign py      = y0_reg * GAIN_Q30;
    assign x1_next = px[PW-1:PRE_SHIFT];
    assign y1_next = py[PW-1:PRE_SHIFT];
    assign h_turn  = {h0_reg, {(TURN_BITS-ANGLE_WIDTH){1'b0}}};
    assign z_raw   = $signed('0 - h_turn);
    assign far     = (z_raw > QUARTER_TURN) || (z_raw < -QUARTER_TURN);
    assign z1_next = far ? {~z_raw[TURN_BITS-1], z_raw[TURN_BITS-2:0]} : z_raw;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            x1_reg    <= x1_next;
            y1_reg    <= y1_next;
            z1_reg    <= z1_next;
            flip1_reg <= far;
        end
    end

    assign x_neg = flip1_reg ? -x1_reg : x1_reg;
    assign y_neg = flip1_reg ? -y1_reg : y1_reg;

    // cordic stages, one step per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        if (i == 0)
        begin : g_first
            fovr_cordic_step #(
                .XW   (XW),
                .STEP (i)
            ) u_step (
                .x_in  (x_neg),
                .y_in  (y_neg),
                .z_in  (z1_reg),
                .x_out (xs_next[i]),
                .y_out (ys_next[i]),
                .z_out (zs_next[i])
            );
        end
        else
        begin : g_rest
            fovr_cordic_step #(
                .XW   (XW),
                .STEP (i)
            ) u_step (
                .x_in  (xs_reg[i-1]),
                .y_in  (ys_reg[i-1]),
                .z_in  (zs_reg[i-1]),
                .x_out (xs_next[i]),
                .y_out (ys_next[i]),
                .z_out (zs_next[i])
            );
        end

        always_ff @(posedge clk)
        begin
            if (adv[i+2])
            begin
                xs_reg[i] <= xs_next[i];
                ys_reg[i] <= ys_next[i];
                zs_reg[i] <= zs_next[i];
            end
        end
    end

    // round half up and saturate
    assign out_x_next = round_sat(xs_reg[CORDIC_STEPS-1]);
    assign out_y_next = round_sat(ys_reg[CORDIC_STEPS-1]);

    always_ff @(posedge clk)
    begin
        if (adv[LAST])
        begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
        end
    end

    assign out_x   = out_x_reg;
    assign out_y   = out_y_reg;
    assign out_rot = rot_reg[LAST];

endmodule

FILE: tb/field_oriented_vector_rotate_core_test.sv
// testbench for the field-oriented vector rotator against a cordic predictor
`timescale 1ns / 1ps

module field_oriented_vector_rotate_core_test;

    localparam int DATA_W      = 16;
    localparam int ANGLE_W     = 16;
    localparam int ROT_STEPS   = 30;
    localparam longint GAIN    = 64'sd652032874;
    localparam longint QUARTER = 64'sd1 << 30;
    localparam longint HALF_LSB = 64'sd32768;
    localparam int IDLE_LIMIT  = 5000;
    localparam int RANDOM_WORDS = 1150;

    localparam longint ARCTAN [ROT_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087,
        667544, 333772, 166886, 83443, 41722,
        20861, 10430, 5215, 2608, 1304,
        652, 326, 163, 81, 41,
        20, 10, 5, 3, 1
    };

    typedef struct {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] rot;
        logic [ANGLE_W-1:0]       heading;
        int                       gap;
        bit                       drain_first;
    } command_t;

    typedef struct {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] rot;
    } drive_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic signed [DATA_W-1:0] cmd_x = '0;
    logic signed [DATA_W-1:0] cmd_y = '0;
    logic signed [DATA_W-1:0] cmd_rot = '0;
    logic [ANGLE_W-1:0]       heading = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_rot;

    command_t command_q[$];
    drive_t   expected_drive_q[$];
    int       mismatch_count = 0;
    int       idle_cycles = 0;

    field_oriented_vector_rotate_core #(
        .DATA_WIDTH (DATA_W),
        .ANGLE_WIDTH(ANGLE_W)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd_x    (cmd_x),
        .cmd_y    (cmd_y),
        .cmd_rot  (cmd_rot),
        .heading  (heading),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_x    (out_x),
        .out_y    (out_y),
        .out_rot  (out_rot)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_drive(input longint v);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (DATA_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // rotate (x, y) by minus the heading through a gain-compensated cordic
    function automatic drive_t field_rotate(input command_t c);
        logic [31:0] phase;
        longint      vx;
        longint      vy;
        longint      vz;
        longint      dx;
        longint      dy;
        drive_t      r;
        phase = 32'd0 - ({16'd0, c.heading} << (32 - ANGLE_W));
        vz = longint'($signed(phase));
        vx = (longint'(c.x) * GAIN) >>> 14;
        vy = (longint'(c.y) * GAIN) >>> 14;
        if (vz > QUARTER || vz < -QUARTER)
        begin
            vx = -vx;
            vy = -vy;
            vz = (vz > 0) ? vz - 2 * QUARTER : vz + 2 * QUARTER;
        end
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vz >= 0)
            begin
                vx = vx - dx;
                vy = vy + dy;
                vz = vz - ARCTAN[i];
            end
            else
            begin
                vx = vx + dx;
                vy = vy - dy;
                vz = vz + ARCTAN[i];
            end
        end
        r.x = DATA_W'(clamp_drive((vx + HALF_LSB) >>> 16));
        r.y = DATA_W'(clamp_drive((vy + HALF_LSB) >>> 16));
        r.rot = c.rot;
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_edge_value();
        case ($urandom_range(0, 6))
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            5: return 16'sd32766;
            default: return 16'sd32767;
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] pick_heading();
        if ($urandom_range(0, 99) >= 20)
            return ANGLE_W'($urandom);
        case ($urandom_range(0, 11))
            0: return 16'd0;
            1: return 16'd8192;
            2: return 16'd16383;
            3: return 16'd16384;
            4: return 16'd16385;
            5: return 16'd32767;
            6: return 16'd32768;
            7: return 16'd32769;
            8: return 16'd49151;
            9: return 16'd49152;
            10: return 16'd49153;
            default: return 16'd65535;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_large();
        logic signed [DATA_W-1:0] m;
        m = DATA_W'($urandom_range(20000, 32767));
        return $urandom_range(0, 1) ? m : -m - 1;
    endfunction

    task automatic queue_command(input int x, input int y, input int rot, input int h,
                                 input bit drain_first);
        command_t c;
        c.x = DATA_W'(x);
        c.y = DATA_W'(y);
        c.rot = DATA_W'(rot);
        c.heading = ANGLE_W'(h);
        c.gap = pick_gap();
        c.drain_first = drain_first;
        command_q.push_back(c);
    endtask

    task automatic check_field(input string name, input logic signed [DATA_W-1:0] exp_v,
                               input logic signed [DATA_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch on %s: expected %0d, got %0d", name, exp_v, act_v);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : driver
        command_t c;
        logic     send;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd_x <= '0;
            cmd_y <= '0;
            cmd_rot <= '0;
            heading <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            send = 1'b0;
            if (command_q.size() > 0)
            begin
                if (command_q[0].gap > 0)
                    command_q[0].gap = command_q[0].gap - 1;
                else if (!(command_q[0].drain_first && expected_drive_q.size() != 0))
                begin
                    c = command_q.pop_front();
                    send = 1'b1;
                    cmd_x <= c.x;
                    cmd_y <= c.y;
                    cmd_rot <= c.rot;
                    heading <= c.heading;
                    expected_drive_q.push_back(field_rotate(c));
                end
            end
            in_valid <= send;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : monitor
        drive_t exp_d;
        int     stall_left;
        int     cyc;
        int     g;
        logic   next_ready;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            cyc = 0;
        end
        else
        begin
            cyc++;
            if (out_valid && out_ready)
            begin
                if (expected_drive_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("output word with no pending command: x %0d y %0d rot %0d",
                                 out_x, out_y, out_rot);
                end
                else
                begin
                    exp_d = expected_drive_q.pop_front();
                    check_field("out_x", exp_d.x, out_x);
                    check_field("out_y", exp_d.y, out_y);
                    check_field("out_rot", exp_d.rot, out_rot);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else if (((cyc >> 9) & 3) == 0)
                next_ready = 1'b1;
            else
            begin
                g = pick_gap();
                stall_left = (g > 0) ? g - 1 : 0;
                next_ready = (g == 0);
            end
            out_ready <= next_ready;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int mode;
        int x;
        int y;
        int rot;
        // zero vector, with and without heading
        queue_command(0, 0, 0, 0, 1'b0);
        queue_command(0, 0, 32767, 12345, 1'b0);
        // axis extremes
        queue_command(32767, 0, -32768, 0, 1'b0);
        queue_command(-32768, 0, 0, 0, 1'b0);
        queue_command(0, 32767, 1, 16384, 1'b0);
        queue_command(0, -32768, -1, 16384, 1'b0);
        // diagonal full scale, outputs saturate
        queue_command(32767, 32767, 100, 8192, 1'b0);
        queue_command(-32768, -32768, -100, 8192, 1'b0);
        queue_command(32767, -32768, 32767, 57344, 1'b0);
        queue_command(-32768, 32767, -32768, 24576, 1'b0);
        queue_command(32767, 32767, 0, 65535, 1'b0);
        // quarter and half turn boundaries
        queue_command(1000, -2000, 5, 32768, 1'b0);
        queue_command(1000, -2000, 6, 49152, 1'b0);
        queue_command(1000, -2000, 7, 16384, 1'b0);
        queue_command(-3000, 2500, 8, 16383, 1'b0);
        queue_command(-3000, 2500, 9, 16385, 1'b0);
        queue_command(-3000, 2500, 10, 49151, 1'b0);
        queue_command(-3000, 2500, 11, 49153, 1'b0);
        queue_command(12000, 9000, 12, 65535, 1'b0);
        queue_command(12000, 9000, 13, 1, 1'b0);
        // tiny vectors
        queue_command(1, -1, 14, 4321, 1'b0);
        queue_command(-1, -1, 15, 32768, 1'b0);
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            mode = $urandom_range(0, 99);
            if (mode < 50)
            begin
                x = int'($signed(DATA_W'($urandom)));
                y = int'($signed(DATA_W'($urandom)));
            end
            else if (mode < 70)
            begin
                x = $urandom_range(0, 128) - 64;
                y = $urandom_range(0, 128) - 64;
            end
            else if (mode < 80)
            begin
                x = pick_edge_value();
                y = pick_edge_value();
            end
            else if (mode < 90)
            begin
                x = pick_large();
                y = pick_large();
            end
            else
            begin
                x = ($urandom_range(0, 1) == 0) ? 0 : int'($signed(DATA_W'($urandom)));
                y = (x != 0) ? 0 : (($urandom_range(0, 1) == 0) ? 0
                                    : int'($signed(DATA_W'($urandom))));
            end
            rot = int'($signed(DATA_W'($urandom)));
            queue_command(x, y, rot, pick_heading(), n == 0 || n == 700);
            // back-to-back stretch
            if (n >= 300 && n < 500)
                command_q[command_q.size() - 1].gap = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (command_q.size() > 0 || in_valid || expected_drive_q.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
hdl/fovr_pkg.sv
hdl/fovr_cordic_step.sv
hdl/field_oriented_vector_rotate_core.sv
tb/field_oriented_vector_rotate_core_test.sv
